[hw/rtl/waypoint_track_guidance_defines.svh]
// Assertion macros for the waypoint track guidance block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef WAYPOINT_TRACK_GUIDANCE_DEFINES_SVH
`define WAYPOINT_TRACK_GUIDANCE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define WTG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wtg_pkg.sv]
// Types, codes and the multiply-accumulate micro-program for the guidance block.
// No dependencies; used by wtg_mac and waypoint_track_guidance.
`timescale 1ns / 1ps

package wtg_pkg;

    // Result codes
    typedef enum logic [2:0] {
        EV_NEXT      = 3'd0,
        EV_OFF_TRACK = 3'd1,
        EV_LEFT      = 3'd2,
        EV_RIGHT     = 3'd3,
        EV_ARRIVED   = 3'd4
    } event_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_ERR_RADIUS  = 3'd0;
    localparam logic [2:0] CFG_POINT_COUNT = 3'd1;
    localparam logic [2:0] CFG_AXIS_X      = 3'd2;
    localparam logic [2:0] CFG_AXIS_Y      = 3'd3;
    localparam logic [2:0] CFG_AXIS_Z      = 3'd4;

    // Register reset values
    localparam logic [15:0]        ERR_RADIUS_RST  = 16'd640;
    localparam logic [6:0]         POINT_COUNT_RST = 7'd64;
    localparam logic signed [14:0] AXIS_X_RST      = -15'sd7864;
    localparam logic signed [14:0] AXIS_Y_RST      = 15'sd10322;
    localparam logic signed [14:0] AXIS_Z_RST      = 15'sd9994;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_TGT,
        ST_RD_PREV,
        ST_DIFF,
        ST_RUN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    // Multiplier operand sources
    typedef enum logic [4:0] {
        SRC_CUR0, SRC_CUR1, SRC_CUR2,
        SRC_SEG0, SRC_SEG1, SRC_SEG2,
        SRC_ERR,
        SRC_CRM_LO0, SRC_CRM_LO1, SRC_CRM_LO2,
        SRC_CRM_HI0, SRC_CRM_HI1, SRC_CRM_HI2,
        SRC_SEG2_LO, SRC_SEG2_HI,
        SRC_ERR2,
        SRC_CR_LO0, SRC_CR_LO1, SRC_CR_LO2,
        SRC_CR_HI0, SRC_CR_HI1, SRC_CR_HI2,
        SRC_AXIS0, SRC_AXIS1, SRC_AXIS2
    } src_t;

    typedef enum logic [1:0] {SH_0, SH_24, SH_25, SH_48} shift_t;

    // Where a finished accumulation is kept
    typedef enum logic [3:0] {
        DST_NONE, DST_CUR2, DST_ERR2, DST_SEG2,
        DST_CR0, DST_CR1, DST_CR2, DST_C2, DST_LIM, DST_DOT
    } dst_t;

    typedef struct packed {
        logic   valid;
        logic   clr;
        logic   neg;
        shift_t sh;
        dst_t   dst;
    } mac_ctl_t;

    typedef struct packed {
        src_t     a;
        src_t     b;
        mac_ctl_t ctl;
    } step_op_t;

    localparam int          OPND_W    = 33;
    localparam int          ACC_W     = 98;
    localparam int          STEP_W    = 5;
    localparam logic [4:0]  LAST_STEP = 5'd29;

    function automatic step_op_t mk_op(src_t a, src_t b, logic clr, logic neg,
                                       shift_t sh, dst_t dst);
        step_op_t op;
        op.a         = a;
        op.b         = b;
        op.ctl.valid = 1'b1;
        op.ctl.clr   = clr;
        op.ctl.neg   = neg;
        op.ctl.sh    = sh;
        op.ctl.dst   = dst;
        return op;
    endfunction

    // Micro-program: squares, cross product, cross magnitude, limit, dot
    function automatic step_op_t step_decode(logic [4:0] s);
        step_op_t op;
        op = '0;
        case (s)
            5'd0:  op = mk_op(SRC_CUR0, SRC_CUR0, 1'b1, 1'b0, SH_0, DST_NONE);
            5'd1:  op = mk_op(SRC_CUR1, SRC_CUR1, 1'b0, 1'b0, SH_0, DST_NONE);
            5'd2:  op = mk_op(SRC_CUR2, SRC_CUR2, 1'b0, 1'b0, SH_0, DST_CUR2);
            5'd3:  op = mk_op(SRC_ERR,  SRC_ERR,  1'b1, 1'b0, SH_0, DST_ERR2);
            5'd4:  op = mk_op(SRC_SEG0, SRC_SEG0, 1'b1, 1'b0, SH_0, DST_NONE);
            5'd5:  op = mk_op(SRC_SEG1, SRC_SEG1, 1'b0, 1'b0, SH_0, DST_NONE);
            5'd6:  op = mk_op(SRC_SEG2, SRC_SEG2, 1'b0, 1'b0, SH_0, DST_SEG2);
            5'd7:  op = mk_op(SRC_SEG1, SRC_CUR2, 1'b1, 1'b0, SH_0, DST_NONE);
            5'd8:  op = mk_op(SRC_SEG2, SRC_CUR1, 1'b0, 1'b1, SH_0, DST_CR0);
            5'd9:  op = mk_op(SRC_SEG2, SRC_CUR0, 1'b1, 1'b0, SH_0, DST_NONE);
            5'd10: op = mk_op(SRC_SEG0, SRC_CUR2, 1'b0, 1'b1, SH_0, DST_CR1);
            5'd11: op = mk_op(SRC_SEG0, SRC_CUR1, 1'b1, 1'b0, SH_0, DST_NONE);
            5'd12: op = mk_op(SRC_SEG1, SRC_CUR0, 1'b0, 1'b1, SH_0, DST_CR2);
            5'd13: op = mk_op(SRC_CRM_LO0, SRC_CRM_LO0, 1'b1, 1'b0, SH_0, DST_NONE);
            5'd14: op = mk_op(SRC_CRM_HI0, SRC_CRM_LO0, 1'b0, 1'b0, SH_25, DST_NONE);
            5'd15: op = mk_op(SRC_CRM_HI0, SRC_CRM_HI0, 1'b0, 1'b0, SH_48, DST_NONE);
            5'd16: op = mk_op(SRC_CRM_LO1, SRC_CRM_LO1, 1'b0, 1'b0, SH_0, DST_NONE);
            5'd17: op = mk_op(SRC_CRM_HI1, SRC_CRM_LO1, 1'b0, 1'b0, SH_25, DST_NONE);
            5'd18: op = mk_op(SRC_CRM_HI1, SRC_CRM_HI1, 1'b0, 1'b0, SH_48, DST_NONE);
            5'd19: op = mk_op(SRC_CRM_LO2, SRC_CRM_LO2, 1'b0, 1'b0, SH_0, DST_NONE);
            5'd20: op = mk_op(SRC_CRM_HI2, SRC_CRM_LO2, 1'b0, 1'b0, SH_25, DST_NONE);
            5'd21: op = mk_op(SRC_CRM_HI2, SRC_CRM_HI2, 1'b0, 1'b0, SH_48, DST_C2);
            5'd22: op = mk_op(SRC_ERR2, SRC_SEG2_LO, 1'b1, 1'b0, SH_0, DST_NONE);
            5'd23: op = mk_op(SRC_ERR2, SRC_SEG2_HI, 1'b0, 1'b0, SH_24, DST_LIM);
            5'd24: op = mk_op(SRC_CR_LO0, SRC_AXIS0, 1'b1, 1'b0, SH_0, DST_NONE);
            5'd25: op = mk_op(SRC_CR_HI0, SRC_AXIS0, 1'b0, 1'b0, SH_24, DST_NONE);
            5'd26: op = mk_op(SRC_CR_LO1, SRC_AXIS1, 1'b0, 1'b0, SH_0, DST_NONE);
            5'd27: op = mk_op(SRC_CR_HI1, SRC_AXIS1, 1'b0, 1'b0, SH_24, DST_NONE);
            5'd28: op = mk_op(SRC_CR_LO2, SRC_AXIS2, 1'b0, 1'b0, SH_0, DST_NONE);
            5'd29: op = mk_op(SRC_CR_HI2, SRC_AXIS2, 1'b0, 1'b0, SH_24, DST_DOT);
            default: op = '0;
        endcase
        return op;
    endfunction

    // Clamp a coordinate difference to 24 bits signed
    function automatic logic signed [23:0] sat24(logic signed [32:0] d);
        logic signed [23:0] r;
        if (d > 33'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (d < -33'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = d[23:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/wtg_if.sv]
// Handshake channels of the guidance block: fix/load words, result words and
// configuration writes. No dependencies.
`timescale 1ns / 1ps

interface wtg_item_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [5:0]         point_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source (output valid, func, point_index, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, func, point_index, pos_x, pos_y, pos_z, output ready);
endinterface

interface wtg_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [5:0] target_point;
    logic [15:0] event_number;
    modport source (output valid, event_res, target_point, event_number, input ready);
    modport sink   (input valid, event_res, target_point, event_number, output ready);
endinterface

interface wtg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/wtg_mac.sv]
// Shared signed 33x33 multiplier with registered product and a wide accumulator.
// Depends on wtg_pkg.
`timescale 1ns / 1ps

module wtg_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [wtg_pkg::OPND_W-1:0]   opnd_a,
    input  logic signed [wtg_pkg::OPND_W-1:0]   opnd_b,
    input  wtg_pkg::mac_ctl_t                   ctl,
    output wtg_pkg::mac_ctl_t                   wr,
    output logic signed [wtg_pkg::ACC_W-1:0]    acc_sum
);

    logic signed [2*wtg_pkg::OPND_W-1:0] prod_reg;
    wtg_pkg::mac_ctl_t                   ctl_reg;
    logic signed [wtg_pkg::ACC_W-1:0]    acc_reg;
    logic signed [wtg_pkg::ACC_W-1:0]    prod_ext;
    logic signed [wtg_pkg::ACC_W-1:0]    term;

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opnd_a * opnd_b;
    end

    // Align and add
    always_comb
    begin
        prod_ext = wtg_pkg::ACC_W'(prod_reg);
        case (ctl_reg.sh)
            wtg_pkg::SH_0:  term = prod_ext;
            wtg_pkg::SH_24: term = prod_ext <<< 24;
            wtg_pkg::SH_25: term = prod_ext <<< 25;
            wtg_pkg::SH_48: term = prod_ext <<< 48;
            default:        term = prod_ext;
        endcase
        acc_sum = (ctl_reg.clr ? '0 : acc_reg) + (ctl_reg.neg ? -term : term);
    end

    always_ff @(posedge clk)
    begin
        if (ctl_reg.valid)
        begin
            acc_reg <= acc_sum;
        end
    end

    assign wr = ctl_reg;

endmodule

[hw/rtl/waypoint_track_guidance.sv]
// Waypoint cross-track guidance: a load word writes one route point; a fix word
// goes from acceptance to a result in the output register through two table
// reads, a difference step, 30 product steps through the single shared 33x33
// multiplier, a drain and a decide step, after which the block is ready again.
// The decide step waits while a held result is not taken; the result register
// frees the fix path while one waits. The route table has no clearing pass.
// Depends on wtg_pkg, wtg_if, wtg_mac and waypoint_track_guidance_defines.svh.
`timescale 1ns / 1ps
`include "waypoint_track_guidance_defines.svh"

module waypoint_track_guidance #(
    parameter int ROUTE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    wtg_item_if.sink           item,
    wtg_result_if.source       result,
    wtg_cfg_if.sink            cfg
);

    localparam int         AW      = $clog2(ROUTE_DEPTH);
    localparam logic [6:0] CNT_MAX = 7'((ROUTE_DEPTH < 64) ? ROUTE_DEPTH : 64);

    wtg_pkg::state_t    state_reg, state_next;
    logic [4:0]         step_reg, step_next;

    logic [15:0]        err_reg;
    logic [6:0]         count_reg;
    logic signed [14:0] axis_reg [3];

    logic [5:0]         target_reg, target_next;
    logic               route_done_reg, route_done_next;
    logic [15:0]        event_count_reg, event_count_next;

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] tgt_reg [3];
    logic signed [23:0] cur_reg [3];
    logic signed [23:0] seg_reg [3];
    logic [47:0]        cur2_reg;
    logic [31:0]        err2_reg;
    logic [47:0]        seg2_reg;
    logic signed [48:0] cr_reg [3];
    logic [47:0]        crm [3];
    logic [95:0]        c2_reg;
    logic [79:0]        lim_reg;
    logic signed [63:0] dot_reg;

    logic [95:0]        route_mem [ROUTE_DEPTH];
    logic [95:0]        rd_data_reg;
    logic [AW-1:0]      rd_addr;

    wtg_pkg::event_t    res_reg, res_next;
    logic [5:0]         out_tp_reg;
    logic [15:0]        out_num_reg;
    logic               out_valid_reg;
    logic               out_load;

    wtg_pkg::step_op_t  op;
    wtg_pkg::mac_ctl_t  mac_ctl, mac_wr;
    logic signed [wtg_pkg::OPND_W-1:0] opnd_a, opnd_b;
    logic signed [wtg_pkg::ACC_W-1:0]  acc_sum;

    logic               fix_acc, load_acc;
    logic [6:0]         cnt_eff;

    assign fix_acc  = item.valid && item.ready && item.func;
    assign load_acc = item.valid && item.ready && !item.func;

    // Configuration port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg     <= wtg_pkg::ERR_RADIUS_RST;
            count_reg   <= wtg_pkg::POINT_COUNT_RST;
            axis_reg[0] <= wtg_pkg::AXIS_X_RST;
            axis_reg[1] <= wtg_pkg::AXIS_Y_RST;
            axis_reg[2] <= wtg_pkg::AXIS_Z_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                wtg_pkg::CFG_ERR_RADIUS:  err_reg     <= cfg.data;
                wtg_pkg::CFG_POINT_COUNT: count_reg   <= cfg.data[6:0];
                wtg_pkg::CFG_AXIS_X:      axis_reg[0] <= cfg.data[14:0];
                wtg_pkg::CFG_AXIS_Y:      axis_reg[1] <= cfg.data[14:0];
                wtg_pkg::CFG_AXIS_Z:      axis_reg[2] <= cfg.data[14:0];
                default: ;
            endcase
        end
    end

    // Route table: one write port, one registered read port
    always_comb
    begin
        if (state_reg == wtg_pkg::ST_RD_TGT)
        begin
            rd_addr = AW'(target_reg);
        end
        else
        begin
            rd_addr = AW'(target_reg - 6'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_acc && (32'(item.point_index) < ROUTE_DEPTH))
        begin
            route_mem[AW'(item.point_index)] <= {item.pos_z, item.pos_y, item.pos_x};
        end
        rd_data_reg <= route_mem[rd_addr];
    end

    // Fix position, target point and saturated differences
    always_ff @(posedge clk)
    begin
        if (fix_acc)
        begin
            pos_reg[0] <= item.pos_x;
            pos_reg[1] <= item.pos_y;
            pos_reg[2] <= item.pos_z;
        end
        if (state_reg == wtg_pkg::ST_RD_PREV)
        begin
            for (int k = 0; k < 3; k++)
            begin
                tgt_reg[k] <= rd_data_reg[32*k +: 32];
            end
        end
        if (state_reg == wtg_pkg::ST_DIFF)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cur_reg[k] <= wtg_pkg::sat24(33'(tgt_reg[k]) - 33'(pos_reg[k]));
                seg_reg[k] <= wtg_pkg::sat24(33'(tgt_reg[k])
                                             - 33'($signed(rd_data_reg[32*k +: 32])));
            end
        end
    end

    // Cross product magnitudes
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            crm[k] = cr_reg[k][48] ? 48'(-cr_reg[k]) : 48'(cr_reg[k]);
        end
    end

    // Operand selection for the shared multiplier
    function automatic logic signed [wtg_pkg::OPND_W-1:0] operand(wtg_pkg::src_t s);
        logic signed [wtg_pkg::OPND_W-1:0] v;
        case (s)
            wtg_pkg::SRC_CUR0:    v = 33'(cur_reg[0]);
            wtg_pkg::SRC_CUR1:    v = 33'(cur_reg[1]);
            wtg_pkg::SRC_CUR2:    v = 33'(cur_reg[2]);
            wtg_pkg::SRC_SEG0:    v = 33'(seg_reg[0]);
            wtg_pkg::SRC_SEG1:    v = 33'(seg_reg[1]);
            wtg_pkg::SRC_SEG2:    v = 33'(seg_reg[2]);
            wtg_pkg::SRC_ERR:     v = $signed({17'd0, err_reg});
            wtg_pkg::SRC_CRM_LO0: v = $signed({9'd0, crm[0][23:0]});
            wtg_pkg::SRC_CRM_LO1: v = $signed({9'd0, crm[1][23:0]});
            wtg_pkg::SRC_CRM_LO2: v = $signed({9'd0, crm[2][23:0]});
            wtg_pkg::SRC_CRM_HI0: v = $signed({9'd0, crm[0][47:24]});
            wtg_pkg::SRC_CRM_HI1: v = $signed({9'd0, crm[1][47:24]});
            wtg_pkg::SRC_CRM_HI2: v = $signed({9'd0, crm[2][47:24]});
            wtg_pkg::SRC_SEG2_LO: v = $signed({9'd0, seg2_reg[23:0]});
            wtg_pkg::SRC_SEG2_HI: v = $signed({9'd0, seg2_reg[47:24]});
            wtg_pkg::SRC_ERR2:    v = $signed({1'b0, err2_reg});
            wtg_pkg::SRC_CR_LO0:  v = $signed({9'd0, cr_reg[0][23:0]});
            wtg_pkg::SRC_CR_LO1:  v = $signed({9'd0, cr_reg[1][23:0]});
            wtg_pkg::SRC_CR_LO2:  v = $signed({9'd0, cr_reg[2][23:0]});
            wtg_pkg::SRC_CR_HI0:  v = 33'($signed(cr_reg[0][48:24]));
            wtg_pkg::SRC_CR_HI1:  v = 33'($signed(cr_reg[1][48:24]));
            wtg_pkg::SRC_CR_HI2:  v = 33'($signed(cr_reg[2][48:24]));
            wtg_pkg::SRC_AXIS0:   v = 33'(axis_reg[0]);
            wtg_pkg::SRC_AXIS1:   v = 33'(axis_reg[1]);
            wtg_pkg::SRC_AXIS2:   v = 33'(axis_reg[2]);
            default:              v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        op      = wtg_pkg::step_decode(step_reg);
        mac_ctl = (state_reg == wtg_pkg::ST_RUN) ? op.ctl : '0;
        opnd_a  = operand(op.a);
        opnd_b  = operand(op.b);
    end

    wtg_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .opnd_a  (opnd_a),
        .opnd_b  (opnd_b),
        .ctl     (mac_ctl),
        .wr      (mac_wr),
        .acc_sum (acc_sum)
    );

    // Keep finished accumulations
    always_ff @(posedge clk)
    begin
        if (mac_wr.valid)
        begin
            case (mac_wr.dst)
                wtg_pkg::DST_CUR2: cur2_reg  <= acc_sum[47:0];
                wtg_pkg::DST_ERR2: err2_reg  <= acc_sum[31:0];
                wtg_pkg::DST_SEG2: seg2_reg  <= acc_sum[47:0];
                wtg_pkg::DST_CR0:  cr_reg[0] <= acc_sum[48:0];
                wtg_pkg::DST_CR1:  cr_reg[1] <= acc_sum[48:0];
                wtg_pkg::DST_CR2:  cr_reg[2] <= acc_sum[48:0];
                wtg_pkg::DST_C2:   c2_reg    <= acc_sum[95:0];
                wtg_pkg::DST_LIM:  lim_reg   <= acc_sum[79:0];
                wtg_pkg::DST_DOT:  dot_reg   <= acc_sum[63:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            wtg_pkg::ST_IDLE:
            begin
                if (fix_acc)
                begin
                    state_next = wtg_pkg::ST_RD_TGT;
                end
            end
            wtg_pkg::ST_RD_TGT:  state_next = wtg_pkg::ST_RD_PREV;
            wtg_pkg::ST_RD_PREV: state_next = wtg_pkg::ST_DIFF;
            wtg_pkg::ST_DIFF:
            begin
                state_next = wtg_pkg::ST_RUN;
                step_next  = '0;
            end
            wtg_pkg::ST_RUN:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == wtg_pkg::LAST_STEP)
                begin
                    state_next = wtg_pkg::ST_DRAIN;
                end
            end
            wtg_pkg::ST_DRAIN:   state_next = wtg_pkg::ST_DECIDE;
            wtg_pkg::ST_DECIDE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = wtg_pkg::ST_IDLE;
                end
            end
            default:             state_next = wtg_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs and the guidance decision
    always_comb
    begin
        item.ready       = (state_reg == wtg_pkg::ST_IDLE);
        out_load         = (state_reg == wtg_pkg::ST_DECIDE) && (!out_valid_reg || result.ready);

        cnt_eff = count_reg;
        if (cnt_eff < 7'd2)
        begin
            cnt_eff = 7'd2;
        end
        if (cnt_eff > CNT_MAX)
        begin
            cnt_eff = CNT_MAX;
        end

        target_next      = target_reg;
        route_done_next  = route_done_reg;
        res_next         = wtg_pkg::EV_ARRIVED;
        if (route_done_reg || ({1'b0, target_reg} >= cnt_eff) || (target_reg == 6'd0))
        begin
            route_done_next = 1'b1;
        end
        else if (cur2_reg < {16'd0, err2_reg})
        begin
            if (({1'b0, target_reg} + 7'd1) >= cnt_eff)
            begin
                route_done_next = 1'b1;
            end
            else
            begin
                target_next = target_reg + 6'd1;
                res_next    = wtg_pkg::EV_NEXT;
            end
        end
        else if (c2_reg > {16'd0, lim_reg})
        begin
            res_next = wtg_pkg::EV_OFF_TRACK;
        end
        else if (dot_reg > 64'sd0)
        begin
            res_next = wtg_pkg::EV_LEFT;
        end
        else
        begin
            res_next = wtg_pkg::EV_RIGHT;
        end
        event_count_next = event_count_reg + 16'd1;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= wtg_pkg::ST_IDLE;
            step_reg        <= '0;
            target_reg      <= 6'd1;
            route_done_reg  <= 1'b0;
            event_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_load)
            begin
                target_reg      <= target_next;
                route_done_reg  <= route_done_next;
                event_count_reg <= event_count_next;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg     <= res_next;
            out_tp_reg  <= target_next;
            out_num_reg <= event_count_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.event_res    = res_reg;
    assign result.target_point = out_tp_reg;
    assign result.event_number = out_num_reg;

    // Checks
    `WTG_ASSERT_NEXT(a_busy_after_fix, fix_acc, !item.ready, "fix accepted but block still ready")
    `WTG_ASSERT_NOW(a_target_nonzero, 1'b1, target_reg != 6'd0, "target index reached zero")
    `WTG_ASSERT_NEXT(a_done_sticky, route_done_reg, route_done_reg, "arrival flag cleared")
    `WTG_ASSERT_NEXT(a_count_step, out_load, event_count_reg == $past(event_count_reg) + 16'd1, "event count did not step")

endmodule
